/* design/clsu_pkg.sv */
// package: operation codes, request, result and register file types for the execute unit
`default_nettype none
package clsu_pkg;

    localparam logic [7:0] SP_RESET   = 8'hFD;
    localparam logic [7:0] STACK_PAGE = 8'h01;
    localparam logic [7:0] PUSH_MARK  = 8'h30;
    localparam int unsigned FLAG_N = 7;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_Z = 1;

    typedef enum logic [4:0] {
        OP_NOP = 5'd0,
        OP_LDA = 5'd1,
        OP_LDX = 5'd2,
        OP_LDY = 5'd3,
        OP_STA = 5'd4,
        OP_STX = 5'd5,
        OP_STY = 5'd6,
        OP_TAX = 5'd7,
        OP_TAY = 5'd8,
        OP_TXA = 5'd9,
        OP_TYA = 5'd10,
        OP_TSX = 5'd11,
        OP_TXS = 5'd12,
        OP_PHA = 5'd13,
        OP_PHP = 5'd14,
        OP_PLA = 5'd15,
        OP_PLP = 5'd16,
        OP_AND = 5'd17,
        OP_EOR = 5'd18,
        OP_ORA = 5'd19,
        OP_BIT = 5'd20
    } t_op;

    typedef struct packed {
        logic [4:0]  req_type;
        logic [7:0]  operand_byte;
        logic [15:0] effective_address;
    } t_req;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] idx_x;
        logic [7:0] idx_y;
        logic [7:0] sp;
        logic [7:0] status;
    } t_arch;

    typedef struct packed {
        logic        mem_write;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        t_arch       regs;
    } t_rsp;

endpackage
`default_nettype wire

/* design/clsu_if.sv */
// interfaces: request and result channels with valid/ready handshake
`default_nettype none
interface clsu_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  req_type;
    logic [7:0]  operand_byte;
    logic [15:0] effective_address;

    modport source(output valid, output req_type, output operand_byte,
                   output effective_address, input ready);
    modport sink(input valid, input req_type, input operand_byte,
                 input effective_address, output ready);
endinterface

interface clsu_rsp_if;
    logic        valid;
    logic        ready;
    logic        mem_write;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  accumulator_out;
    logic [7:0]  index_x_out;
    logic [7:0]  index_y_out;
    logic [7:0]  stack_ptr_out;
    logic [7:0]  status_out;

    modport source(output valid, output mem_write, output write_address,
                   output write_data, output accumulator_out, output index_x_out,
                   output index_y_out, output stack_ptr_out, output status_out,
                   input ready);
    modport sink(input valid, input mem_write, input write_address,
                 input write_data, input accumulator_out, input index_x_out,
                 input index_y_out, input stack_ptr_out, input status_out,
                 output ready);
endinterface
`default_nettype wire

/* design/clsu_exec.sv */
// execute logic: next register file, flags and memory write for one request
`default_nettype none
module clsu_exec (
    input  wire clsu_pkg::t_arch i_arch,
    input  wire clsu_pkg::t_req  i_req,
    output clsu_pkg::t_arch      o_arch,
    output clsu_pkg::t_rsp       o_rsp
);
    import clsu_pkg::*;

    t_arch      n_arch;
    logic       wr;
    logic [15:0] waddr;
    logic [7:0] wdata;
    logic       nz_upd;
    logic [7:0] nz_val;
    logic [7:0] m;

    assign m = i_req.operand_byte;

    always_comb begin
        n_arch = i_arch;
        wr     = 1'b0;
        waddr  = 16'h0000;
        wdata  = 8'h00;
        nz_upd = 1'b0;
        nz_val = 8'h00;
        case (t_op'(i_req.req_type))
            OP_LDA: begin
                n_arch.acc = m;
                nz_upd = 1'b1;
                nz_val = m;
            end
            OP_LDX: begin
                n_arch.idx_x = m;
                nz_upd = 1'b1;
                nz_val = m;
            end
            OP_LDY: begin
                n_arch.idx_y = m;
                nz_upd = 1'b1;
                nz_val = m;
            end
            OP_STA: begin
                wr = 1'b1;
                waddr = i_req.effective_address;
                wdata = i_arch.acc;
            end
            OP_STX: begin
                wr = 1'b1;
                waddr = i_req.effective_address;
                wdata = i_arch.idx_x;
            end
            OP_STY: begin
                wr = 1'b1;
                waddr = i_req.effective_address;
                wdata = i_arch.idx_y;
            end
            OP_TAX: begin
                n_arch.idx_x = i_arch.acc;
                nz_upd = 1'b1;
                nz_val = i_arch.acc;
            end
            OP_TAY: begin
                n_arch.idx_y = i_arch.acc;
                nz_upd = 1'b1;
                nz_val = i_arch.acc;
            end
            OP_TXA: begin
                n_arch.acc = i_arch.idx_x;
                nz_upd = 1'b1;
                nz_val = i_arch.idx_x;
            end
            OP_TYA: begin
                n_arch.acc = i_arch.idx_y;
                nz_upd = 1'b1;
                nz_val = i_arch.idx_y;
            end
            OP_TSX: begin
                n_arch.idx_x = i_arch.sp;
                nz_upd = 1'b1;
                nz_val = i_arch.sp;
            end
            OP_TXS: begin
                n_arch.sp = i_arch.idx_x;
            end
            OP_PHA: begin
                wr = 1'b1;
                waddr = {STACK_PAGE, i_arch.sp};
                wdata = i_arch.acc;
                n_arch.sp = i_arch.sp - 8'd1;
            end
            OP_PHP: begin
                wr = 1'b1;
                waddr = {STACK_PAGE, i_arch.sp};
                wdata = i_arch.status | PUSH_MARK;
                n_arch.sp = i_arch.sp - 8'd1;
            end
            OP_PLA: begin
                n_arch.sp = i_arch.sp + 8'd1;
                n_arch.acc = m;
                nz_upd = 1'b1;
                nz_val = m;
            end
            OP_PLP: begin
                n_arch.sp = i_arch.sp + 8'd1;
                n_arch.status = m & ~PUSH_MARK;
            end
            OP_AND: begin
                n_arch.acc = i_arch.acc & m;
                nz_upd = 1'b1;
                nz_val = i_arch.acc & m;
            end
            OP_EOR: begin
                n_arch.acc = i_arch.acc ^ m;
                nz_upd = 1'b1;
                nz_val = i_arch.acc ^ m;
            end
            OP_ORA: begin
                n_arch.acc = i_arch.acc | m;
                nz_upd = 1'b1;
                nz_val = i_arch.acc | m;
            end
            OP_BIT: begin
                n_arch.status[FLAG_N] = m[FLAG_N];
                n_arch.status[FLAG_V] = m[FLAG_V];
                n_arch.status[FLAG_Z] = ~|(i_arch.acc & m);
            end
            default: begin
            end
        endcase
        if (nz_upd) begin
            n_arch.status[FLAG_N] = nz_val[7];
            n_arch.status[FLAG_Z] = ~|nz_val;
        end
    end

    assign o_arch = n_arch;
    assign o_rsp  = '{mem_write: wr, write_address: waddr, write_data: wdata,
                      regs: n_arch};

endmodule
`default_nettype wire

/* design/cpu_load_logic_stack_unit.sv */
// top level: execute unit for loads, stores, transfers, stack and logic operations
// - i_req carries one operation per request: req_type, operand_byte and
//   effective_address; for pulls operand_byte is the byte at the stack top
// - o_rsp returns one result per request: the memory write (address and data
//   are zero when mem_write is low) and all registers after the operation
// - a request accepted into the input register passes through the execute logic
//   into the result register, which drives o_rsp
// - throughput: one request per cycle if o_rsp is not stalled; the register file
//   updates as a request moves from the input register into the result register
// - when the receiver stalls, the result register holds and the input register
//   keeps one more request; i_req.ready falls only when both are full
// - reset clears both stages, a, x, y and status to zero and the stack
//   pointer to 0xFD
`default_nettype none
module cpu_load_logic_stack_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    clsu_req_if.sink   i_req,
    clsu_rsp_if.source o_rsp
);
    import clsu_pkg::*;

    logic   r_in_valid;
    t_req   r_in;
    logic   r_out_valid;
    t_rsp   r_out;
    t_arch  r_arch;
    t_arch  n_arch;
    t_rsp   n_out;
    logic   out_free;
    logic   move;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign move        = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || out_free;

    clsu_exec u_exec (
        .i_arch(r_arch),
        .i_req (r_in),
        .o_arch(n_arch),
        .o_rsp (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= '{req_type: i_req.req_type, operand_byte: i_req.operand_byte,
                      effective_address: i_req.effective_address};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch <= '{acc: 8'h00, idx_x: 8'h00, idx_y: 8'h00, sp: SP_RESET,
                        status: 8'h00};
        end else if (move) begin
            r_arch <= n_arch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.mem_write       = r_out.mem_write;
    assign o_rsp.write_address   = r_out.write_address;
    assign o_rsp.write_data      = r_out.write_data;
    assign o_rsp.accumulator_out = r_out.regs.acc;
    assign o_rsp.index_x_out     = r_out.regs.idx_x;
    assign o_rsp.index_y_out     = r_out.regs.idx_y;
    assign o_rsp.stack_ptr_out   = r_out.regs.sp;
    assign o_rsp.status_out      = r_out.regs.status;

    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_valid)
        else $error("result register not loaded after move");

    a_in_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_in))
        else $error("input register lost a pending request");

    a_push_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && (r_in.req_type == OP_PHA || r_in.req_type == OP_PHP)
        |=> (r_out.regs.sp == $past(r_arch.sp) - 8'd1) && r_out.mem_write)
        else $error("push did not decrement stack pointer");

    a_status_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_arch.status[5:4] == 2'b00 && r_out.regs == r_arch)
        else $error("result registers disagree with register file");

endmodule
`default_nettype wire
